/* rtl/ffa_pkg.sv */
// Shared types for the first-fit allocator.
// No dependencies; used by the cell, the ring and the top level.
`default_nettype none
package ffa_pkg;

    typedef struct packed {
        logic shift;
    } ring_ctl_t;

endpackage
`default_nettype wire

/* rtl/ffa_cell.sv */
// One table entry of a ring; loads its right neighbor on shift.
// Depends on ffa_pkg.
`default_nettype none
module ffa_cell #(
    parameter int             W       = 1,
    parameter logic [W-1:0]   RST_VAL = '0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ffa_pkg::ring_ctl_t ctl,
    input  wire logic [W-1:0]      d,
    output logic [W-1:0]           q
);

    logic [W-1:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= RST_VAL;
        end
        else if (ctl.shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

/* rtl/ffa_ring.sv */
// Row of table cells that rotates one place toward the head per shift.
// Depends on ffa_pkg and ffa_cell.
`default_nettype none
module ffa_ring #(
    parameter int           W        = 1,
    parameter int           N        = 2,
    parameter logic [W-1:0] HEAD_RST = '0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ffa_pkg::ring_ctl_t ctl,
    input  wire logic [W-1:0]      tail,
    output logic [W-1:0]           head,
    output logic [W-1:0]           next
);

    logic [W-1:0] q [N];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [W-1:0] d;
        if (i == N - 1)
        begin : g_last
            assign d = tail;
        end
        else
        begin : g_mid
            assign d = q[i+1];
        end
        ffa_cell #(
            .W       (W),
            .RST_VAL ((i == 0) ? HEAD_RST : '0)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .d     (d),
            .q     (q[i])
        );
    end

    assign head = q[0];
    assign next = q[1];

endmodule
`default_nettype wire

/* rtl/first_fit_allocator_coalescing_unit.sv */
// First-fit allocator top level: sequencer plus used and free table rings.
// Depends on ffa_pkg and ffa_ring.
//
// Both tables live in rings of CHUNK_CAP cells and are edited while one full
// rotation streams every entry past the head. A free runs a used-table
// rotation, a free-table rotation and the result; an allocate runs word
// rounding (divide, then correct), a free-table rotation, a used-table rotation
// and the result. Rejected requests end after the first check or rotation.
// One item is in flight at a time; the result register holds while stalled.
`default_nettype none
module first_fit_allocator_coalescing_unit #(
    parameter int WORD_CAP   = 4096,
    parameter int CHUNK_CAP  = 64,
    parameter int WORD_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [15:0] request_bytes,
    input  wire logic [11:0] free_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [11:0]      block_address,
    output logic [1:0]       status
);

    localparam int AW   = $clog2(WORD_CAP);
    localparam int SW   = $clog2(WORD_CAP + 1);
    localparam int EW   = AW + SW;
    localparam int CN   = $clog2(CHUNK_CAP + 1);
    localparam int TW   = $clog2(CHUNK_CAP);
    localparam int CW   = (AW > 12) ? AW : 12;
    localparam int XW   = 17;
    localparam int MS   = 20;
    localparam int PW   = XW + MS;
    localparam int M0   = (1 << MS) / WORD_BYTES;
    localparam int UWW  = ((SW > XW) ? SW : XW) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_CORR  = 3'd2;
    localparam logic [2:0] S_FPASS = 3'd3;
    localparam logic [2:0] S_UPASS = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [2:0] M_SEEK  = 3'd0;
    localparam logic [2:0] M_PASS  = 3'd1;
    localparam logic [2:0] M_INS   = 3'd2;
    localparam logic [2:0] M_REM   = 3'd3;
    localparam logic [2:0] M_RPEND = 3'd4;
    localparam logic [2:0] M_IPEND = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic OP_ALLOC = 1'b0;

    logic [2:0]    state_reg, state_next;
    logic          op_reg, op_next;
    logic [15:0]   bytes_reg, bytes_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic [XW-1:0] q0_reg, q0_next;
    logic [XW-1:0] words_reg, words_next;
    logic [TW-1:0] t_reg, t_next;
    logic [2:0]    mode_reg, mode_next;
    logic [EW-1:0] carry_reg, carry_next;
    logic          found_reg, found_next;
    logic [AW-1:0] base_reg, base_next;
    logic [SW-1:0] sz_reg, sz_next;
    logic [CN-1:0] pc_reg, pc_next;
    logic [CN-1:0] ucnt_reg, ucnt_next;
    logic [CN-1:0] fcnt_reg, fcnt_next;
    logic [SW-1:0] uwords_reg, uwords_next;
    logic [1:0]    st_reg, st_next;
    logic [AW-1:0] res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    logic [11:0]   out_addr_reg, out_addr_next;
    logic [1:0]    out_status_reg, out_status_next;

    ffa_pkg::ring_ctl_t fctl, uctl;
    logic [EW-1:0] f_head, f_next, u_head, u_next;
    logic [EW-1:0] a, b, beff, y;
    logic [AW-1:0] a_start, b_start;
    logic [SW-1:0] a_size, b_size, w, s_end, a_end, start_sum;
    logic          va, vb, last;
    logic [XW-1:0] x, prod, r, words_c;
    logic [PW-1:0] prodq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_SEEK;
            found_reg     <= 1'b0;
            t_reg         <= '0;
            pc_reg        <= '0;
            ucnt_reg      <= '0;
            fcnt_reg      <= CN'(1);
            uwords_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            found_reg     <= found_next;
            t_reg         <= t_next;
            pc_reg        <= pc_next;
            ucnt_reg      <= ucnt_next;
            fcnt_reg      <= fcnt_next;
            uwords_reg    <= uwords_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        bytes_reg      <= bytes_next;
        addr_reg       <= addr_next;
        q0_reg         <= q0_next;
        words_reg      <= words_next;
        carry_reg      <= carry_next;
        base_reg       <= base_next;
        sz_reg         <= sz_next;
        st_reg         <= st_next;
        res_reg        <= res_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign fctl.shift = (state_reg == S_FPASS);
    assign uctl.shift = (state_reg == S_UPASS);

    ffa_ring #(
        .W        (EW),
        .N        (CHUNK_CAP),
        .HEAD_RST ({AW'(0), SW'(WORD_CAP)})
    ) u_free_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fctl),
        .tail  (y),
        .head  (f_head),
        .next  (f_next)
    );

    ffa_ring #(
        .W        (EW),
        .N        (CHUNK_CAP),
        .HEAD_RST ('0)
    ) u_used_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (uctl),
        .tail  (y),
        .head  (u_head),
        .next  (u_next)
    );

    assign a       = (state_reg == S_FPASS) ? f_head : u_head;
    assign b       = (state_reg == S_FPASS) ? f_next : u_next;
    assign a_start = a[EW-1:SW];
    assign a_size  = a[SW-1:0];
    assign b_start = b[EW-1:SW];
    assign b_size  = b[SW-1:0];
    assign last    = (t_reg == TW'(CHUNK_CAP - 1));
    assign va      = (CN'(t_reg) < pc_reg);
    assign vb      = ((CN'(t_reg) + CN'(1)) < pc_reg) && !last;
    assign beff    = last ? a : b;
    assign w       = SW'(words_reg);
    assign s_end   = SW'(base_reg) + sz_reg;
    assign a_end   = SW'(a_start) + a_size;
    assign start_sum = SW'(a_start) + w;

    assign x     = XW'(bytes_reg) + XW'(WORD_BYTES - 1);
    assign prodq = PW'(x) * PW'(M0);
    assign prod  = XW'(q0_reg * XW'(WORD_BYTES));
    assign r     = x - prod;
    assign words_c = (r >= XW'(WORD_BYTES)) ? (q0_reg + XW'(1)) : q0_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        bytes_next      = bytes_reg;
        addr_next       = addr_reg;
        q0_next         = q0_reg;
        words_next      = words_reg;
        t_next          = t_reg;
        mode_next       = mode_reg;
        carry_next      = carry_reg;
        found_next      = found_reg;
        base_next       = base_reg;
        sz_next         = sz_reg;
        pc_next         = pc_reg;
        ucnt_next       = ucnt_reg;
        fcnt_next       = fcnt_reg;
        uwords_next     = uwords_reg;
        st_next         = st_reg;
        res_next        = res_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        y               = a;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    bytes_next = request_bytes;
                    addr_next  = CW'(free_address);
                    t_next     = '0;
                    mode_next  = M_SEEK;
                    found_next = 1'b0;
                    res_next   = '0;
                    if (opcode == OP_ALLOC)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        pc_next    = ucnt_reg;
                        state_next = S_UPASS;
                    end
                end
            end
            S_DIV:
            begin
                q0_next    = prodq[PW-1:MS];
                state_next = S_CORR;
            end
            S_CORR:
            begin
                words_next = words_c;
                pc_next    = fcnt_reg;
                priority if (ucnt_reg >= CN'(CHUNK_CAP))
                begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end
                else if (words_c == '0 ||
                         (UWW'(uwords_reg) + UWW'(words_c)) > UWW'(WORD_CAP))
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FPASS;
                end
            end
            S_UPASS:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    unique case (mode_reg)
                        M_SEEK:
                        begin
                            if (!(va && a_start < base_reg))
                            begin
                                y          = {base_reg, w};
                                carry_next = a;
                                mode_next  = M_INS;
                            end
                        end
                        M_INS:
                        begin
                            y          = carry_reg;
                            carry_next = a;
                        end
                        default:
                        begin
                            y = a;
                        end
                    endcase
                end
                else
                begin
                    unique case (mode_reg)
                        M_SEEK:
                        begin
                            if (va && CW'(a_start) == addr_reg)
                            begin
                                found_next = 1'b1;
                                base_next  = a_start;
                                sz_next    = a_size;
                                y          = beff;
                                mode_next  = M_REM;
                            end
                        end
                        M_REM:
                        begin
                            y = beff;
                        end
                        default:
                        begin
                            y = a;
                        end
                    endcase
                end
                t_next = t_reg + TW'(1);
                if (last)
                begin
                    t_next    = '0;
                    mode_next = M_SEEK;
                    if (op_reg == OP_ALLOC)
                    begin
                        ucnt_next  = ucnt_reg + CN'(1);
                        st_next    = ST_OK;
                        state_next = S_DONE;
                    end
                    else if (found_next)
                    begin
                        ucnt_next   = ucnt_reg - CN'(1);
                        uwords_next = (uwords_reg >= sz_next) ? (uwords_reg - sz_next) : '0;
                        pc_next     = fcnt_reg;
                        st_next     = ST_OK;
                        state_next  = S_FPASS;
                    end
                    else
                    begin
                        st_next    = ST_UNKNOWN;
                        state_next = S_DONE;
                    end
                end
            end
            S_FPASS:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    unique case (mode_reg)
                        M_SEEK:
                        begin
                            if (va && a_size >= w)
                            begin
                                found_next = 1'b1;
                                base_next  = a_start;
                                if (a_size == w)
                                begin
                                    y         = beff;
                                    mode_next = M_REM;
                                    fcnt_next = fcnt_reg - CN'(1);
                                end
                                else
                                begin
                                    y         = {start_sum[AW-1:0], a_size - w};
                                    mode_next = M_PASS;
                                end
                            end
                        end
                        M_REM:
                        begin
                            y = beff;
                        end
                        default:
                        begin
                            y = a;
                        end
                    endcase
                end
                else
                begin
                    unique case (mode_reg)
                        M_SEEK:
                        begin
                            priority if (t_reg == '0 && !(va && a_start <= base_reg))
                            begin
                                priority if (va && SW'(a_start) == s_end)
                                begin
                                    y         = {base_reg, a_size + sz_reg};
                                    mode_next = M_PASS;
                                end
                                else if (pc_reg < CN'(CHUNK_CAP))
                                begin
                                    y          = {base_reg, sz_reg};
                                    carry_next = a;
                                    mode_next  = M_INS;
                                    fcnt_next  = fcnt_reg + CN'(1);
                                end
                                else
                                begin
                                    mode_next = M_PASS;
                                end
                            end
                            else if (va && a_start <= base_reg &&
                                     !(vb && b_start <= base_reg))
                            begin
                                priority if (a_end == SW'(base_reg) &&
                                             vb && SW'(b_start) == s_end)
                                begin
                                    y         = {a_start, a_size + sz_reg + b_size};
                                    mode_next = M_REM;
                                    fcnt_next = fcnt_reg - CN'(1);
                                end
                                else if (a_end == SW'(base_reg))
                                begin
                                    y         = {a_start, a_size + sz_reg};
                                    mode_next = M_PASS;
                                end
                                else if (vb && SW'(b_start) == s_end)
                                begin
                                    mode_next = M_RPEND;
                                end
                                else if (pc_reg < CN'(CHUNK_CAP))
                                begin
                                    mode_next = M_IPEND;
                                    fcnt_next = fcnt_reg + CN'(1);
                                end
                                else
                                begin
                                    mode_next = M_PASS;
                                end
                            end
                            else
                            begin
                                y = a;
                            end
                        end
                        M_RPEND:
                        begin
                            y         = {base_reg, a_size + sz_reg};
                            mode_next = M_PASS;
                        end
                        M_IPEND:
                        begin
                            y          = {base_reg, sz_reg};
                            carry_next = a;
                            mode_next  = M_INS;
                        end
                        M_INS:
                        begin
                            y          = carry_reg;
                            carry_next = a;
                        end
                        M_REM:
                        begin
                            y = beff;
                        end
                        default:
                        begin
                            y = a;
                        end
                    endcase
                end
                t_next = t_reg + TW'(1);
                if (last)
                begin
                    t_next    = '0;
                    mode_next = M_SEEK;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (found_next)
                        begin
                            uwords_next = uwords_reg + w;
                            res_next    = base_next;
                            pc_next     = ucnt_reg;
                            st_next     = ST_OK;
                            state_next  = S_UPASS;
                        end
                        else
                        begin
                            st_next    = ST_NOFIT;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = 12'(res_reg);
                    out_status_next = st_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign block_address = out_addr_reg;
    assign status        = out_status_reg;

endmodule
`default_nettype wire

/* test/tb_first_fit_allocator_coalescing_unit.sv */
// Testbench for the first-fit allocator: directed and random allocate/free beats,
// checked against an in-bench model of the used and free tables.
// Depends on first_fit_allocator_coalescing_unit only.
`default_nettype none
module tb_first_fit_allocator_coalescing_unit;

    localparam int WORD_CAP   = 4096;
    localparam int CHUNK_CAP  = 64;
    localparam int WORD_BYTES = 8;
    localparam int WATCH_LIMIT = 20000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [11:0] addr;
        logic [1:0]  st;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [15:0] request_bytes;
    logic [11:0] free_address;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] block_address;
    logic [1:0]  status;

    first_fit_allocator_coalescing_unit #(
        .WORD_CAP(WORD_CAP), .CHUNK_CAP(CHUNK_CAP), .WORD_BYTES(WORD_BYTES)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .request_bytes(request_bytes), .free_address(free_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .block_address(block_address), .status(status)
    );

    int unsigned used_base [CHUNK_CAP];
    int unsigned used_len  [CHUNK_CAP];
    int unsigned used_n;
    int unsigned hole_base [CHUNK_CAP];
    int unsigned hole_len  [CHUNK_CAP];
    int unsigned hole_n;
    int unsigned words_taken;

    grant_t      pending_grants[$];
    int          errors;
    int          idle_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    task automatic hole_drop(input int unsigned idx);
        for (int unsigned i = idx; i + 1 < hole_n; i++)
        begin
            hole_base[i] = hole_base[i + 1];
            hole_len[i]  = hole_len[i + 1];
        end
        hole_n--;
    endtask

    task automatic hole_add(input int unsigned b, input int unsigned l);
        int unsigned pos;
        pos = 0;
        if (hole_n >= CHUNK_CAP)
            return;
        while (pos < hole_n && hole_base[pos] < b)
            pos++;
        for (int unsigned i = hole_n; i > pos; i--)
        begin
            hole_base[i] = hole_base[i - 1];
            hole_len[i]  = hole_len[i - 1];
        end
        hole_base[pos] = b;
        hole_len[pos]  = l;
        hole_n++;
    endtask

    task automatic used_add(input int unsigned b, input int unsigned l);
        int unsigned pos;
        pos = 0;
        while (pos < used_n && used_base[pos] < b)
            pos++;
        for (int unsigned i = used_n; i > pos; i--)
        begin
            used_base[i] = used_base[i - 1];
            used_len[i]  = used_len[i - 1];
        end
        used_base[pos] = b;
        used_len[pos]  = l;
        used_n++;
    endtask

    task automatic merge_hole(input int unsigned b, input int unsigned l);
        int unsigned idx;
        bit right;
        bit left;
        idx = 0;
        right = 0;
        left = 0;
        while (idx < hole_n && hole_base[idx] <= b)
            idx++;
        if (idx < hole_n && hole_base[idx] == b + l)
        begin
            hole_base[idx] -= l;
            hole_len[idx]  += l;
            right = 1;
        end
        if (idx > 0 && hole_base[idx - 1] + hole_len[idx - 1] == b)
        begin
            left = 1;
            if (right)
            begin
                hole_len[idx - 1] += hole_len[idx];
                hole_drop(idx);
            end
            else
                hole_len[idx - 1] += l;
        end
        if (!right && !left)
            hole_add(b, l);
    endtask

    function automatic void table_reset();
        used_n = 0;
        hole_n = 1;
        hole_base[0] = 0;
        hole_len[0] = WORD_CAP;
        words_taken = 0;
    endfunction

    task automatic predict_grant(input logic op, input logic [15:0] bytes,
                                 input logic [11:0] fa, output grant_t g);
        int unsigned words;
        int unsigned b;
        int unsigned l;
        g.addr = '0;
        g.st = ST_OK;
        if (op == OP_ALLOC)
        begin
            words = (int'(bytes) + WORD_BYTES - 1) / WORD_BYTES;
            if (used_n >= CHUNK_CAP)
                g.st = ST_FULL;
            else if (words == 0 || words_taken + words > WORD_CAP)
                g.st = ST_NOFIT;
            else
            begin
                g.st = ST_NOFIT;
                for (int unsigned i = 0; i < hole_n; i++)
                begin
                    if (hole_len[i] >= words)
                    begin
                        b = hole_base[i];
                        if (hole_len[i] > words)
                        begin
                            hole_base[i] = b + words;
                            hole_len[i]  = hole_len[i] - words;
                        end
                        else
                            hole_drop(i);
                        used_add(b, words);
                        words_taken += words;
                        g.addr = b[11:0];
                        g.st = ST_OK;
                        break;
                    end
                end
            end
        end
        else
        begin
            g.st = ST_UNKNOWN;
            for (int unsigned i = 0; i < used_n; i++)
            begin
                if (used_base[i] == fa)
                begin
                    b = used_base[i];
                    l = used_len[i];
                    for (int unsigned j = i; j + 1 < used_n; j++)
                    begin
                        used_base[j] = used_base[j + 1];
                        used_len[j]  = used_len[j + 1];
                    end
                    used_n--;
                    merge_hole(b, l);
                    words_taken = (words_taken >= l) ? words_taken - l : 0;
                    g.st = ST_OK;
                    break;
                end
            end
        end
    endtask

    task automatic send_beat(input logic op, input logic [15:0] bytes,
                             input logic [11:0] fa);
        grant_t g;
        while (($urandom % 100) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        request_bytes <= bytes;
        free_address <= fa;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_grant(op, bytes, fa, g);
        pending_grants.push_back(g);
        @(negedge clk);
    endtask

    task automatic alloc_beat(input logic [15:0] bytes);
        send_beat(OP_ALLOC, bytes, 12'($urandom));
    endtask

    task automatic free_beat(input logic [11:0] fa);
        send_beat(OP_FREE, 16'($urandom), fa);
    endtask

    function automatic logic [11:0] pick_used();
        if (used_n == 0)
            return 12'($urandom);
        return used_base[$urandom_range(used_n - 1, 0)][11:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                report("result beat count", 1, 0);
            end
            else
            begin
                grant_t w;
                w = pending_grants.pop_front();
                if (block_address !== w.addr)
                    report("block_address", block_address, w.addr);
                if (status !== w.st)
                    report("status", status, w.st);
            end
        end
    end

    always @(negedge clk)
        out_stall <= (($urandom % 100) < recv_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("tb_first_fit_allocator_coalescing_unit NOT OK");
            $finish;
        end
    end

    task automatic test_edges();
        alloc_beat(16'd0);
        alloc_beat(16'd1);
        alloc_beat(16'd8);
        alloc_beat(16'd9);
        alloc_beat(16'hFFFF);
        alloc_beat(16'd16);
        free_beat(12'd4095);
        free_beat(12'd1);
        free_beat(12'd0);
        free_beat(12'd3);
        free_beat(12'd2);
        free_beat(12'd1);
        alloc_beat(16'd32768);
        alloc_beat(16'd8);
        free_beat(12'd0);
        free_beat(12'd0);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < CHUNK_CAP; i++)
            alloc_beat(16'd8);
        alloc_beat(16'd8);
        alloc_beat(16'd0);
        for (int i = 0; i < CHUNK_CAP; i += 2)
            free_beat(12'(i));
        for (int i = 1; i < CHUNK_CAP; i += 2)
            free_beat(12'(i));
    endtask

    task automatic test_random(input int n);
        int unsigned r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < 45)
            begin
                if ($urandom_range(9, 0) == 0)
                    alloc_beat(16'($urandom));
                else
                    alloc_beat(16'($urandom_range(800, 1)));
            end
            else if (r < 90)
                free_beat(pick_used());
            else
                free_beat(12'($urandom));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 17;
        recv_idle_pct = 54;
        in_valid = 1'b0;
        out_stall = 1'b0;
        opcode = OP_ALLOC;
        request_bytes = '0;
        free_address = '0;
        table_reset();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_edges();
        test_table_full();
        test_random(535);
        send_idle_pct = 54;
        recv_idle_pct = 17;
        test_random(535);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(535);
        drain();
        if (errors == 0)
            $display("tb_first_fit_allocator_coalescing_unit OK");
        else
            $display("tb_first_fit_allocator_coalescing_unit NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
